@@ rtl/core/scope_frame_crc16_framer_macros.svh @@
// ---------------------------------------------------------------------------
// scope_frame_crc16_framer_macros: assertion macros
// shared concurrent check forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef SCOPE_FRAME_CRC16_FRAMER_MACROS_SVH
`define SCOPE_FRAME_CRC16_FRAMER_MACROS_SVH

// same-cycle implication
`define SFCF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcf check failed");

// next-cycle implication
`define SFCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcf check failed");

`endif

@@ rtl/core/sfcf_pkg.sv @@
// ---------------------------------------------------------------------------
// sfcf_pkg: frame builder constants and crc function
// frame geometry, crc-16/modbus constants and the one-byte crc update
// ---------------------------------------------------------------------------
package sfcf_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CHAN_SLOTS   = 4;
    localparam int CHAN_W       = 16;
    localparam int DATA_BYTES   = 2 * NUM_CHANNELS;
    localparam int FRAME_BYTES  = DATA_BYTES + 2;
    localparam int DATA_W       = DATA_BYTES * 8;
    localparam int FRAME_W      = FRAME_BYTES * 8;
    localparam int BYTE_IDX_W   = $clog2(FRAME_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [15:0]       crc_t;

    // one byte through the reflected crc, lsb first
    function automatic crc_t crc_feed(input crc_t crc, input logic [7:0] data_byte);
        crc_t c;
        c = crc ^ {8'h00, data_byte};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ rtl/core/sfcf_crc_stage.sv @@
// ---------------------------------------------------------------------------
// sfcf_crc_stage: one pipeline stage of the frame crc
// folds one data byte into the running crc and carries the frame data along
// ---------------------------------------------------------------------------
module sfcf_crc_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  sfcf_pkg::crc_t in_crc,
    input  sfcf_pkg::data_t in_data,
    input  logic [7:0]     in_byte,
    output logic           out_valid,
    input  logic           out_stall,
    output sfcf_pkg::crc_t out_crc,
    output sfcf_pkg::data_t out_data
);

    logic            valid_reg;
    logic            valid_next;
    sfcf_pkg::crc_t  crc_reg;
    sfcf_pkg::data_t data_reg;
    logic            load;

    assign in_stall = valid_reg && out_stall;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        if (!in_stall)
            valid_next = in_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            crc_reg  <= sfcf_pkg::crc_feed(in_crc, in_byte);
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_crc   = crc_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/sfcf_serializer.sv @@
// ---------------------------------------------------------------------------
// sfcf_serializer: frame to byte stream
// holds one finished frame and sends it one byte per transfer
// ---------------------------------------------------------------------------
module sfcf_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sfcf_pkg::crc_t  in_crc,
    input  sfcf_pkg::data_t in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    localparam logic [sfcf_pkg::BYTE_IDX_W-1:0] LAST_IDX =
        sfcf_pkg::BYTE_IDX_W'(sfcf_pkg::FRAME_BYTES - 1);

    logic                                valid_reg;
    logic                                valid_next;
    logic [sfcf_pkg::BYTE_IDX_W-1:0]     idx_reg;
    logic [sfcf_pkg::BYTE_IDX_W-1:0]     idx_next;
    logic [sfcf_pkg::FRAME_W-1:0]        frame_reg;
    logic                                send;
    logic                                done;
    logic                                load;

    assign out_last = (idx_reg == LAST_IDX);
    assign send     = valid_reg && !out_stall;
    assign done     = send && out_last;
    assign in_stall = valid_reg && !done;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (send)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // crc low byte sits just above the data, crc high byte on top
    always_ff @(posedge clk)
    begin
        if (load)
            frame_reg <= {in_crc, in_data};
    end

    assign out_valid = valid_reg;
    assign out_byte  = frame_reg[idx_reg * 8 +: 8];

endmodule

@@ rtl/core/scope_frame_crc16_framer.sv @@
// ---------------------------------------------------------------------------
// scope_frame_crc16_framer: four-channel scope frame builder
// 16-bit channel words in, crc-16/modbus protected byte frame out
// ---------------------------------------------------------------------------
// Each item transfer of four channel words yields one frame of ten byte
// transfers: channel 0 low and high byte, then channels 1 to 3 the same way,
// then the crc-16/modbus of those eight bytes (init 0xffff, reflected poly
// 0xa001, no final xor), low byte then high byte; frame_last marks the crc
// high byte. The crc runs in an eight-stage pipeline, one data byte per
// stage, followed by a frame register that streams bytes out; an item passes
// through all eight crc stage registers and then the frame register. The byte
// port carries one byte per cycle while frame_stall is low, frames follow each
// other with no idle byte slot, and up to eight more items are held in the
// pipeline while a frame is being sent. Nothing persists between frames;
// reset only clears the valid bits and the byte index.
// ---------------------------------------------------------------------------
module scope_frame_crc16_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [15:0] channel_0,
    input  logic [15:0] channel_1,
    input  logic [15:0] channel_2,
    input  logic [15:0] channel_3,
    output logic        frame_valid,
    input  logic        frame_stall,
    output logic [7:0]  frame_byte,
    output logic        frame_last
);

`include "scope_frame_crc16_framer_macros.svh"

    localparam int NB = sfcf_pkg::DATA_BYTES;

    // all channel slots packed, channel 0 in the low word
    logic [sfcf_pkg::CHAN_SLOTS*sfcf_pkg::CHAN_W-1:0] all_chan;
    sfcf_pkg::data_t                                  item_data;

    // pipeline links, index k feeds stage k
    logic            pipe_valid [0:NB];
    logic            pipe_stall [0:NB];
    sfcf_pkg::crc_t  pipe_crc   [0:NB];
    sfcf_pkg::data_t pipe_data  [0:NB];

    assign all_chan  = {channel_3, channel_2, channel_1, channel_0};
    assign item_data = all_chan[sfcf_pkg::DATA_W-1:0];

    // head of the pipe: crc starts from its init value
    assign pipe_valid[0] = item_valid;
    assign pipe_crc[0]   = sfcf_pkg::CRC_INIT;
    assign pipe_data[0]  = item_data;
    assign item_stall    = pipe_stall[0];

    // one crc stage per data byte, byte k folded in at stage k
    for (genvar k = 0; k < NB; k++)
    begin : g_stage
        sfcf_crc_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[k]),
            .in_stall  (pipe_stall[k]),
            .in_crc    (pipe_crc[k]),
            .in_data   (pipe_data[k]),
            .in_byte   (pipe_data[k][k*8 +: 8]),
            .out_valid (pipe_valid[k+1]),
            .out_stall (pipe_stall[k+1]),
            .out_crc   (pipe_crc[k+1]),
            .out_data  (pipe_data[k+1])
        );
    end

    // finished frame to byte transfers
    sfcf_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_valid[NB]),
        .in_stall  (pipe_stall[NB]),
        .in_crc    (pipe_crc[NB]),
        .in_data   (pipe_data[NB]),
        .out_valid (frame_valid),
        .out_stall (frame_stall),
        .out_byte  (frame_byte),
        .out_last  (frame_last)
    );

    // a stalled item means the first stage is holding one
    `SFCF_ASSERT_SAME(a_stall_has_head, item_stall, pipe_valid[1])
    // inside a frame the next byte is always ready right after a transfer
    `SFCF_ASSERT_NEXT(a_frame_no_gap, frame_valid && !frame_stall && !frame_last, frame_valid)
    // after the last byte with no frame waiting, the output goes idle
    `SFCF_ASSERT_NEXT(a_idle_after_last,
        frame_valid && !frame_stall && frame_last && !pipe_valid[NB], !frame_valid)

endmodule
